[design/smls_pkg.sv]
// Package for the stepper level-move sequencer.
// Holds the phase encoding, register indexes and the level move table.
// No dependencies.
`timescale 1ns / 1ps

package smls_pkg;

  // Move phase, one-hot
  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhAccel = 4'b0010,
    PhFlat  = 4'b0100,
    PhDecel = 4'b1000
  } phase_e;

  // Configuration register indexes
  localparam logic [1:0] CfgLevelSteps = 2'd0;
  localparam logic [1:0] CfgRampPulses = 2'd1;
  localparam logic [1:0] CfgPctThresh  = 2'd2;
  localparam logic [1:0] CfgIdleTmo    = 2'd3;

  // Register reset values
  localparam logic [15:0] LevelStepsRst = 16'd1107;
  localparam logic [3:0]  RampPulsesRst = 4'd4;
  localparam logic [7:0]  PctThreshRst  = 8'd12;
  localparam logic [23:0] IdleTmoRst    = 24'd60000;

  // Saturation limits
  localparam logic [9:0]  PctCountMax = 10'd1023;
  localparam logic [23:0] IdleMax     = 24'hFFFFFF;

  // One row of the level move table
  typedef struct packed {
    logic [1:0] next_level;
    logic       dir;
    logic [6:0] pct;
  } move_t;

  // Look up next level, stepper direction and opto-toggle percent
  function automatic move_t move_lookup(logic host_dir, logic [1:0] lv);
    move_t m;
    unique case ({host_dir, lv})
      3'b0_00: m = '{next_level: 2'd1, dir: 1'b0, pct: 7'd5};
      3'b0_01: m = '{next_level: 2'd2, dir: 1'b0, pct: 7'd98};
      3'b0_10: m = '{next_level: 2'd3, dir: 1'b1, pct: 7'd45};
      3'b0_11: m = '{next_level: 2'd0, dir: 1'b1, pct: 7'd66};
      3'b1_00: m = '{next_level: 2'd3, dir: 1'b0, pct: 7'd33};
      3'b1_01: m = '{next_level: 2'd0, dir: 1'b1, pct: 7'd98};
      3'b1_10: m = '{next_level: 2'd1, dir: 1'b1, pct: 7'd5};
      3'b1_11: m = '{next_level: 2'd2, dir: 1'b0, pct: 7'd85};
    endcase
    return m;
  endfunction

endpackage

[design/stepper_level_move_sequencer.sv]
// Stepper level-move sequencer: ramp segments, percent toggle, idle timeout.
// Depends on smls_pkg.
// The result of an accepted request is registered in the output register.
// Throughput: one request per clock; a new request is taken while the result
// is taken in the same cycle, and input stalls only while a result waits unread.
// The segment search at move start and after each pulse is a combinational priority pick over
// the 2*NUM_MODES+1 ramp and flat segments.
// Reset (async, active low) returns state and registers to defaults; output empty.
`timescale 1ns / 1ps

module stepper_level_move_sequencer #(
  parameter int NUM_MODES   = 6,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        host_dir_i,
  input  logic        fault_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        step_pulse_o,
  output logic        step_dir_o,
  output logic [2:0]  microstep_mode_o,
  output logic        home_line_o,
  output logic        driver_enable_o,
  output logic        busy_res_o,
  output logic [1:0]  level_o,
  output logic        move_done_o,
  output logic        request_dropped_o
);

  localparam int NumSeg  = 2 * NUM_MODES + 1;
  localparam int PosW    = $clog2(NumSeg);
  localparam int SearchW = PosW + 1;
  localparam int RampMul = 2 * NUM_MODES;
  localparam logic [PosW-1:0] NmPos    = PosW'(NUM_MODES);
  localparam logic [2:0]      LastMode = 3'(NUM_MODES - 1);

  // ramp segment length for one mode
  function automatic logic [COUNT_WIDTH-1:0] ramp_cnt(logic [3:0] rp, logic [2:0] m);
    logic [31:0] w;
    w = {28'd0, rp} << m;
    return w[COUNT_WIDTH-1:0];
  endfunction

  // configuration registers
  logic [15:0] level_steps_q;
  logic [3:0]  ramp_pulses_q;
  logic [7:0]  pct_thresh_q;
  logic [23:0] idle_tmo_q;

  // sequencer state
  smls_pkg::phase_e        phase_q, phase_d;
  logic [PosW-1:0]         pos_q, pos_d;
  logic [2:0]              mode_q, mode_d;
  logic [COUNT_WIDTH-1:0]  rem_q, rem_d;
  logic                    dir_q, dir_d;
  logic [1:0]              cur_level_q, cur_level_d;
  logic [1:0]              next_level_q, next_level_d;
  logic [7:0]              pip_q, pip_d;
  logic [9:0]              pct_cnt_q, pct_cnt_d;
  logic [6:0]              target_q, target_d;
  logic                    armed_q, armed_d;
  logic                    home_q, home_d;
  logic                    last_hdir_q, last_hdir_d;
  logic                    fault_q, fault_d;
  logic [23:0]             idle_q, idle_d;
  logic                    en_q, en_d;
  logic                    pulse_d, done_d, dropped_d;

  logic accept;
  logic out_free;

  // segment search
  logic [NUM_MODES-1:0]   nz_mode;
  logic [NumSeg-1:0]      seg_ne;
  logic [15:0]            ramp_total;
  logic [15:0]            flat_diff;
  logic [31:0]            flat_ext;
  logic [COUNT_WIDTH-1:0] flat_cnt;
  logic                   flat_nz;
  logic [SearchW-1:0]     seg_start;
  logic                   seg_found;
  logic [PosW-1:0]        seg_pos;
  smls_pkg::phase_e       seg_phase;
  logic [2:0]             seg_mode;
  logic [COUNT_WIDTH-1:0] seg_len;
  smls_pkg::move_t        mv;
  logic [COUNT_WIDTH-1:0] rem_dec;
  logic [9:0]             pct_inc;
  logic [23:0]            idle_inc;

  // handshake: stall only while a result waits and is not taken
  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = !out_free;
  assign accept     = in_valid_i && out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_steps_q <= smls_pkg::LevelStepsRst;
      ramp_pulses_q <= smls_pkg::RampPulsesRst;
      pct_thresh_q  <= smls_pkg::PctThreshRst;
      idle_tmo_q    <= smls_pkg::IdleTmoRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        smls_pkg::CfgLevelSteps: level_steps_q <= cfg_data_i[15:0];
        smls_pkg::CfgRampPulses: ramp_pulses_q <= cfg_data_i[3:0];
        smls_pkg::CfgPctThresh:  pct_thresh_q  <= cfg_data_i[7:0];
        smls_pkg::CfgIdleTmo:    idle_tmo_q    <= cfg_data_i;
      endcase
    end
  end

  // flat run length
  assign ramp_total = 16'(ramp_pulses_q * RampMul);
  assign flat_diff  = level_steps_q - ramp_total;
  assign flat_ext   = {16'd0, flat_diff};
  assign flat_cnt   = (level_steps_q > ramp_total) ? flat_ext[COUNT_WIDTH-1:0] : '0;
  assign flat_nz    = |flat_cnt;

  // mark non-empty segments in move order: accel modes high..0, flat, decel 0..high
  for (genvar m = 0; m < NUM_MODES; m++) begin : g_nz
    assign nz_mode[m] = |ramp_cnt(ramp_pulses_q, 3'(m));
  end
  for (genvar i = 0; i < NumSeg; i++) begin : g_seg
    if (i < NUM_MODES) begin : g_acc
      assign seg_ne[i] = nz_mode[NUM_MODES-1-i];
    end else if (i == NUM_MODES) begin : g_flat
      assign seg_ne[i] = flat_nz;
    end else begin : g_dec
      assign seg_ne[i] = nz_mode[i-NUM_MODES-1];
    end
  end

  // pick the first non-empty segment at or after the start position
  assign seg_start = (req_type_i) ? '0 : SearchW'(pos_q) + SearchW'(1);

  always_comb begin
    seg_found = 1'b0;
    seg_pos   = '0;
    for (int i = NumSeg - 1; i >= 0; i--) begin
      if (seg_ne[i] && (SearchW'(i) >= seg_start)) begin
        seg_found = 1'b1;
        seg_pos   = PosW'(i);
      end
    end
  end

  // decode the picked segment
  always_comb begin
    if (seg_pos < NmPos) begin
      seg_phase = smls_pkg::PhAccel;
      seg_mode  = 3'(NmPos - PosW'(1) - seg_pos);
    end else if (seg_pos == NmPos) begin
      seg_phase = smls_pkg::PhFlat;
      seg_mode  = 3'd0;
    end else begin
      seg_phase = smls_pkg::PhDecel;
      seg_mode  = 3'(seg_pos - NmPos - PosW'(1));
    end
    seg_len = (seg_phase == smls_pkg::PhFlat) ? flat_cnt : ramp_cnt(ramp_pulses_q, seg_mode);
  end

  assign mv       = smls_pkg::move_lookup(host_dir_i, cur_level_q);
  assign rem_dec  = (rem_q != '0) ? rem_q - COUNT_WIDTH'(1) : '0;
  assign pct_inc  = (pct_cnt_q < smls_pkg::PctCountMax) ? pct_cnt_q + 10'd1 : pct_cnt_q;
  assign idle_inc = (idle_q != smls_pkg::IdleMax) ? idle_q + 24'd1 : idle_q;

  // next state for one accepted request
  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    mode_d       = mode_q;
    rem_d        = rem_q;
    dir_d        = dir_q;
    cur_level_d  = cur_level_q;
    next_level_d = next_level_q;
    pip_d        = pip_q;
    pct_cnt_d    = pct_cnt_q;
    target_d     = target_q;
    armed_d      = armed_q;
    home_d       = home_q;
    last_hdir_d  = last_hdir_q;
    fault_d      = fault_q | fault_in_i;
    idle_d       = idle_q;
    en_d         = en_q;
    pulse_d      = 1'b0;
    done_d       = 1'b0;
    dropped_d    = 1'b0;

    if (req_type_i) begin
      if (phase_q != smls_pkg::PhIdle) begin
        // drop a move request while busy
        dropped_d = 1'b1;
      end else begin
        // start a move
        if (host_dir_i != last_hdir_q) begin
          home_d      = ~home_q;
          last_hdir_d = host_dir_i;
        end
        next_level_d = mv.next_level;
        dir_d        = mv.dir;
        target_d     = mv.pct;
        armed_d      = 1'b1;
        pct_cnt_d    = '0;
        en_d         = 1'b1;
        idle_d       = '0;
        if (seg_found) begin
          phase_d = seg_phase;
          pos_d   = seg_pos;
          mode_d  = seg_mode;
          rem_d   = seg_len;
        end else begin
          // every segment empty: finish at once
          home_d      = ~home_d;
          cur_level_d = mv.next_level;
          phase_d     = smls_pkg::PhIdle;
          rem_d       = '0;
          mode_d      = LastMode;
          done_d      = 1'b1;
        end
      end
    end else if (phase_q != smls_pkg::PhIdle) begin
      // issue one step pulse
      pulse_d = 1'b1;
      if (pip_q >= pct_thresh_q) begin
        pip_d     = '0;
        pct_cnt_d = pct_inc;
        if (armed_q && (pct_inc >= {3'd0, target_q})) begin
          armed_d = 1'b0;
          home_d  = ~home_d;
        end
      end else begin
        pip_d = pip_q + 8'd1;
      end
      if (rem_dec != '0) begin
        rem_d = rem_dec;
      end else if (seg_found) begin
        phase_d = seg_phase;
        pos_d   = seg_pos;
        mode_d  = seg_mode;
        rem_d   = seg_len;
      end else begin
        // last pulse of the move
        home_d      = ~home_d;
        cur_level_d = next_level_q;
        phase_d     = smls_pkg::PhIdle;
        rem_d       = '0;
        mode_d      = LastMode;
        done_d      = 1'b1;
      end
    end else begin
      // idle tick: count and drop enable on fault or timeout
      if (fault_d || (idle_inc > idle_tmo_q)) begin
        en_d   = 1'b0;
        idle_d = '0;
      end else begin
        idle_d = idle_inc;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= smls_pkg::PhIdle;
      pos_q        <= '0;
      mode_q       <= '0;
      rem_q        <= '0;
      dir_q        <= 1'b0;
      cur_level_q  <= '0;
      next_level_q <= '0;
      pip_q        <= '0;
      pct_cnt_q    <= '0;
      target_q     <= '0;
      armed_q      <= 1'b0;
      home_q       <= 1'b0;
      last_hdir_q  <= 1'b1;
      fault_q      <= 1'b0;
      idle_q       <= '0;
      en_q         <= 1'b1;
    end else if (accept) begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      mode_q       <= mode_d;
      rem_q        <= rem_d;
      dir_q        <= dir_d;
      cur_level_q  <= cur_level_d;
      next_level_q <= next_level_d;
      pip_q        <= pip_d;
      pct_cnt_q    <= pct_cnt_d;
      target_q     <= target_d;
      armed_q      <= armed_d;
      home_q       <= home_d;
      last_hdir_q  <= last_hdir_d;
      fault_q      <= fault_d;
      idle_q       <= idle_d;
      en_q         <= en_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      step_pulse_o      <= pulse_d;
      step_dir_o        <= dir_d;
      microstep_mode_o  <= mode_d;
      home_line_o       <= home_d;
      driver_enable_o   <= en_d;
      busy_res_o        <= (phase_d != smls_pkg::PhIdle);
      level_o           <= cur_level_d;
      move_done_o       <= done_d;
      request_dropped_o <= dropped_d;
    end
  end

endmodule

[verif/tb_stepper_level_move_sequencer.sv]
// Self-checking testbench for the stepper level-move sequencer.
// Predicts every result in place and checks it against the output channel.
// Depends on smls_pkg and stepper_level_move_sequencer.
`timescale 1ns / 1ps

module tb_stepper_level_move_sequencer;

  localparam int NumModes    = 6;
  localparam int CountWidth  = 16;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 4;
  localparam int HoldCycles  = 200;
  localparam int MaxPrinted  = 40;
  localparam int RandomEnd   = 260;

  // One expected result of the sequencer
  typedef struct packed {
    logic       pulse;
    logic       dir;
    logic [2:0] mode;
    logic       home;
    logic       enable;
    logic       busy;
    logic [1:0] level;
    logic       done;
    logic       dropped;
  } seq_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic        host_dir;
  logic        fault_in;
  logic        out_valid;
  logic        out_stall;
  logic        step_pulse;
  logic        step_dir;
  logic [2:0]  microstep_mode;
  logic        home_line;
  logic        driver_enable;
  logic        busy_res;
  logic [1:0]  level;
  logic        move_done;
  logic        request_dropped;

  stepper_level_move_sequencer #(
    .NUM_MODES  (NumModes),
    .COUNT_WIDTH(CountWidth)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (req_type),
    .host_dir_i       (host_dir),
    .fault_in_i       (fault_in),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .step_pulse_o     (step_pulse),
    .step_dir_o       (step_dir),
    .microstep_mode_o (microstep_mode),
    .home_line_o      (home_line),
    .driver_enable_o  (driver_enable),
    .busy_res_o       (busy_res),
    .level_o          (level),
    .move_done_o      (move_done),
    .request_dropped_o(request_dropped)
  );

  // Predicted configuration
  int unsigned cfg_steps;
  int unsigned cfg_ramp;
  int unsigned cfg_thresh;
  int unsigned cfg_idle_tmo;

  // Predicted sequencer state
  logic [1:0]        cur_lvl;
  smls_pkg::phase_e  mv_phase;
  logic [2:0]        mode_idx;
  int unsigned       seg_left;
  logic              mv_dir;
  logic [1:0]        lvl_next;
  logic [7:0]        pulse_cnt;
  logic [9:0]        pct_cnt;
  logic [6:0]        pct_target;
  logic              pct_armed;
  logic              home;
  logic              last_dir;
  logic              fault_seen;
  logic [23:0]       idle_cnt;
  logic              drv_en;

  seq_out_t    pending_outputs[$];
  seq_out_t    oldest_output;
  int          errors;
  int          results_seen;
  int          cycle_count;
  int          items_sent;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  int          hold_request;

  // Level move table: next level, stepper direction, opto-toggle percent
  function automatic smls_pkg::move_t route_for(logic hdir, logic [1:0] lv);
    smls_pkg::move_t r;
    case ({hdir, lv})
      3'b0_00: r = '{next_level: 2'd1, dir: 1'b0, pct: 7'd5};
      3'b0_01: r = '{next_level: 2'd2, dir: 1'b0, pct: 7'd98};
      3'b0_10: r = '{next_level: 2'd3, dir: 1'b1, pct: 7'd45};
      3'b0_11: r = '{next_level: 2'd0, dir: 1'b1, pct: 7'd66};
      3'b1_00: r = '{next_level: 2'd3, dir: 1'b0, pct: 7'd33};
      3'b1_01: r = '{next_level: 2'd0, dir: 1'b1, pct: 7'd98};
      3'b1_10: r = '{next_level: 2'd1, dir: 1'b1, pct: 7'd5};
      default: r = '{next_level: 2'd2, dir: 1'b0, pct: 7'd85};
    endcase
    return r;
  endfunction

  function automatic int unsigned ramp_len(logic [2:0] m);
    return (cfg_ramp << m) & 32'hFFFF;
  endfunction

  // Step to the next segment that has pulses; return 0 when the move is out of segments
  function automatic bit next_pulse_segment();
    int unsigned ramp_total;
    bit searching;
    bit found;
    searching = 1'b1;
    found = 1'b0;
    while (searching) begin
      if (mv_phase == smls_pkg::PhAccel) begin
        if (mode_idx > 3'd0) begin
          mode_idx--;
          seg_left = ramp_len(mode_idx);
        end else begin
          ramp_total = cfg_ramp * 2 * NumModes;
          mv_phase = smls_pkg::PhFlat;
          seg_left = (cfg_steps > ramp_total) ? ((cfg_steps - ramp_total) & 32'hFFFF) : 0;
        end
      end else if (mv_phase == smls_pkg::PhFlat) begin
        mv_phase = smls_pkg::PhDecel;
        mode_idx = 3'd0;
        seg_left = ramp_len(3'd0);
      end else if (mv_phase == smls_pkg::PhDecel && int'(mode_idx) + 1 < NumModes) begin
        mode_idx++;
        seg_left = ramp_len(mode_idx);
      end else begin
        searching = 1'b0;
      end
      if (searching && seg_left != 0) begin
        found = 1'b1;
        searching = 1'b0;
      end
    end
    return found;
  endfunction

  function automatic void end_move();
    home = ~home;
    cur_lvl = lvl_next;
    mv_phase = smls_pkg::PhIdle;
    seg_left = 0;
  endfunction

  // Advance the predicted sequencer by one request and return its outputs
  function automatic seq_out_t advance_move(bit req, bit hdir, bit flt);
    seq_out_t o;
    smls_pkg::move_t route;
    bit pulse;
    bit done;
    bit dropped;
    pulse = 1'b0;
    done = 1'b0;
    dropped = 1'b0;
    if (flt) fault_seen = 1'b1;
    if (req) begin
      if (mv_phase != smls_pkg::PhIdle) begin
        dropped = 1'b1;
      end else begin
        if (hdir != last_dir) begin
          home = ~home;
          last_dir = hdir;
        end
        route = route_for(hdir, cur_lvl);
        lvl_next = route.next_level;
        mv_dir = route.dir;
        pct_target = route.pct;
        pct_armed = 1'b1;
        pct_cnt = '0;
        drv_en = 1'b1;
        idle_cnt = '0;
        mv_phase = smls_pkg::PhAccel;
        mode_idx = 3'(NumModes - 1);
        seg_left = ramp_len(mode_idx);
        if (seg_left == 0 && !next_pulse_segment()) begin
          end_move();
          done = 1'b1;
        end
      end
    end else if (mv_phase != smls_pkg::PhIdle) begin
      pulse = 1'b1;
      if (32'(pulse_cnt) >= cfg_thresh) begin
        pulse_cnt = '0;
        if (pct_cnt < smls_pkg::PctCountMax) pct_cnt++;
        if (pct_armed && pct_cnt >= 10'(pct_target)) begin
          pct_armed = 1'b0;
          home = ~home;
        end
      end else begin
        pulse_cnt++;
      end
      if (seg_left > 0) seg_left--;
      if (seg_left == 0 && !next_pulse_segment()) begin
        end_move();
        done = 1'b1;
      end
    end else begin
      if (idle_cnt < smls_pkg::IdleMax) idle_cnt++;
      if (fault_seen || 32'(idle_cnt) > cfg_idle_tmo) begin
        drv_en = 1'b0;
        idle_cnt = '0;
      end
    end
    o.pulse   = pulse;
    o.dir     = mv_dir;
    o.mode    = mode_idx;
    o.home    = home;
    o.enable  = drv_en;
    o.busy    = (mv_phase != smls_pkg::PhIdle);
    o.level   = cur_lvl;
    o.done    = done;
    o.dropped = dropped;
    return o;
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= MaxPrinted) $display("ERROR: result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request, wait for it to be taken, then record its outputs
  task automatic send_request(bit req, bit hdir, bit flt);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= req;
    host_dir <= hdir;
    fault_in <= flt;
    do @(posedge clk_i); while (in_stall);
    pending_outputs.push_back(advance_move(req, hdir, flt));
    items_sent++;
  endtask

  task automatic send_tick();
    send_request(1'b0, 1'(($urandom_range(0, 1))), 1'b0);
  endtask

  // Tick until the predicted move is over
  task automatic finish_move_ticks();
    while (mv_phase != smls_pkg::PhIdle) send_tick();
  endtask

  // Hold off new requests until every output has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all four registers, one per cycle; upper data bits carry junk on the first three
  task automatic write_registers(int unsigned steps, int unsigned ramp, int unsigned thr,
                                 int unsigned tmo);
    cfg_we    <= 1'b1;
    cfg_index <= smls_pkg::CfgLevelSteps;
    cfg_data  <= {8'($urandom_range(0, 255)), 16'(steps)};
    @(posedge clk_i);
    cfg_steps = steps & 32'hFFFF;
    cfg_index <= smls_pkg::CfgRampPulses;
    cfg_data  <= {20'($urandom_range(0, 1048575)), 4'(ramp)};
    @(posedge clk_i);
    cfg_ramp = ramp & 32'hF;
    cfg_index <= smls_pkg::CfgPctThresh;
    cfg_data  <= {16'($urandom_range(0, 65535)), 8'(thr)};
    @(posedge clk_i);
    cfg_thresh = thr & 32'hFF;
    cfg_index <= smls_pkg::CfgIdleTmo;
    cfg_data  <= 24'(tmo);
    @(posedge clk_i);
    cfg_idle_tmo = tmo & 32'hFFFFFF;
    cfg_we <= 1'b0;
  endtask

  // Every table route, empty moves, idle drop, a busy drop and a short flat run
  task automatic test_directed();
    send_tick();
    send_tick();
    wait_results_drained();
    write_registers(0, 0, 0, 0);
    repeat (4) send_request(1'b1, 1'b1, 1'b0);
    repeat (4) send_request(1'b1, 1'b0, 1'b0);
    send_tick();
    send_tick();
    wait_results_drained();
    write_registers(3, 0, 0, 2);
    send_request(1'b1, 1'b1, 1'b0);
    send_request(1'b1, 1'b0, 1'b0);
    repeat (6) send_tick();
    wait_results_drained();
  endtask

  // Mostly well-formed moves with random content, plus dropped requests
  task automatic test_random_moves();
    int n;
    int kind;
    int unsigned ramp;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    while (items_sent < RandomEnd) begin
      kind = $urandom_range(0, 3);
      if (kind < 2) begin
        ramp = 0;
        write_registers($urandom_range(0, 24), ramp, $urandom_range(0, 3),
                        $urandom_range(0, 12));
      end else if (kind == 2) begin
        ramp = 1;
        write_registers($urandom_range(0, 60), ramp, 0, $urandom_range(0, 40));
      end else begin
        ramp = $urandom_range(0, 1);
        write_registers($urandom_range(0, 30), ramp, $urandom_range(0, 255),
                        $urandom_range(0, 16777215));
      end
      n = (ramp != 0) ? 140 : 40;
      repeat (n) begin
        if (mv_phase == smls_pkg::PhIdle && $urandom_range(0, 2) == 0)
          send_request(1'b1, 1'($urandom_range(0, 1)), 1'b0);
        else if (mv_phase != smls_pkg::PhIdle && $urandom_range(0, 19) == 0)
          send_request(1'b1, 1'($urandom_range(0, 1)), 1'b0);
        else
          send_tick();
      end
      finish_move_ticks();
      wait_results_drained();
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_backpressure();
    write_registers(10, 0, 255, 5);
    gaps_on = 1'b0;
    hold_request = HoldCycles;
    send_request(1'b1, 1'b0, 1'b0);
    repeat (11) send_tick();
    finish_move_ticks();
    wait_results_drained();
    gaps_on = 1'b1;
  endtask

  // Long move: pulses in every ramp mode, a flat run and the percent toggle
  task automatic test_long_move();
    write_registers(60, 1, 0, 24'hFFFFFF);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    send_request(1'b1, 1'($urandom_range(0, 1)), 1'b0);
    while (mv_phase != smls_pkg::PhIdle) begin
      if ($urandom_range(0, 49) == 0) send_request(1'b1, 1'($urandom_range(0, 1)), 1'b0);
      else send_tick();
    end
    wait_results_drained();
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  // Latch a driver fault; idle ticks keep dropping the enable from then on
  task automatic test_fault_latch();
    bit flt;
    write_registers(4, 0, 0, 3);
    for (int i = 0; i < 60; i++) begin
      flt = (i == 20) || (i > 10 && $urandom_range(0, 9) == 0);
      if (mv_phase == smls_pkg::PhIdle && $urandom_range(0, 3) == 0)
        send_request(1'b1, 1'($urandom_range(0, 1)), flt);
      else
        send_request(1'b0, 1'($urandom_range(0, 1)), flt);
    end
    finish_move_ticks();
    wait_results_drained();
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("stepper_level_move_sequencer test failed");
      $finish;
    end
  end

  // Drive the output stall: short random stalls, rare long ones, one long hold-off
  initial begin
    int burst;
    int r;
    int n;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        burst = 0;
      end else if (!stall_on) begin
        out_stall <= 1'b0;
        burst = 0;
      end else if (burst > 0) begin
        burst--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_stall <= 1'b0;
        end else if (r < 97) begin
          out_stall <= 1'b1;
          burst = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          burst = $urandom_range(8, 40);
        end
      end
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        oldest_output = pending_outputs.pop_front();
        check_field("step_pulse", 32'(step_pulse), 32'(oldest_output.pulse));
        check_field("step_dir", 32'(step_dir), 32'(oldest_output.dir));
        check_field("microstep_mode", 32'(microstep_mode), 32'(oldest_output.mode));
        check_field("home_line", 32'(home_line), 32'(oldest_output.home));
        check_field("driver_enable", 32'(driver_enable), 32'(oldest_output.enable));
        check_field("busy_res", 32'(busy_res), 32'(oldest_output.busy));
        check_field("level", 32'(level), 32'(oldest_output.level));
        check_field("move_done", 32'(move_done), 32'(oldest_output.done));
        check_field("request_dropped", 32'(request_dropped), 32'(oldest_output.dropped));
      end
      results_seen++;
    end
  end

  // Reset, run the tests in turn, then report
  initial begin
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= smls_pkg::CfgLevelSteps;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    req_type  <= 1'b0;
    host_dir  <= 1'b0;
    fault_in  <= 1'b0;
    cfg_steps    = 32'(smls_pkg::LevelStepsRst);
    cfg_ramp     = 32'(smls_pkg::RampPulsesRst);
    cfg_thresh   = 32'(smls_pkg::PctThreshRst);
    cfg_idle_tmo = 32'(smls_pkg::IdleTmoRst);
    cur_lvl    = 2'd0;
    mv_phase   = smls_pkg::PhIdle;
    mode_idx   = 3'd0;
    seg_left   = 0;
    mv_dir     = 1'b0;
    lvl_next   = 2'd0;
    pulse_cnt  = '0;
    pct_cnt    = '0;
    pct_target = '0;
    pct_armed  = 1'b0;
    home       = 1'b0;
    last_dir   = 1'b1;
    fault_seen = 1'b0;
    idle_cnt   = '0;
    drv_en     = 1'b1;
    errors       = 0;
    results_seen = 0;
    cycle_count  = 0;
    items_sent   = 0;
    hold_request = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_moves();
    test_backpressure();
    test_long_move();
    test_fault_latch();
    wait_results_drained();
    if (errors == 0) begin
      $display("stepper_level_move_sequencer test passed");
    end else begin
      $display("stepper_level_move_sequencer test failed");
    end
    $finish;
  end

endmodule

[files.f]
design/smls_pkg.sv
design/stepper_level_move_sequencer.sv
verif/tb_stepper_level_move_sequencer.sv
